// ===== sv/bs_pkg.sv =====
// Shared constants, command and status types for the bitonic sorter.
// Used by the channel interfaces, the controller, the datapath and the top level.
package bs_pkg;

    localparam int DATA_W     = 32;
    localparam int DEPTH      = 64;
    localparam int CAPACITY   = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int BANK_DEPTH = DEPTH / 2;
    localparam int BANK_AW    = 5;
    localparam int LOG_W      = 3;

    localparam logic signed [DATA_W-1:0] PAD_VALUE = 32'sh7FFF_FFFF;
    localparam logic [LOG_W-1:0]         LAST_KLOG = 3'd6;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,
        OP_CE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] index;
        logic             last;
        logic [BANK_AW-1:0] pair;
        logic [LOG_W-1:0] jlog;
        logic [LOG_W-1:0] klog;
        logic             pad_en;
        logic [CNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ===== sv/bs_if.sv =====
// Valid/ready channel interfaces for the bitonic sorter input and output.
// Depends on bs_pkg for the data width.
interface bs_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [bs_pkg::DATA_W-1:0] value;
    logic                             last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface bs_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [bs_pkg::DATA_W-1:0] sorted_value;
    logic                             last_out;

    modport source (output valid, output sorted_value, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

// ===== sv/bitonic_sorter.sv =====
// Bitonic sorter top level: collects signed 32-bit values and returns them in ascending order.
// Depends on bs_pkg, bs_in_if/bs_out_if, bs_ctrl and bs_datapath.
//
// Values enter on i_in, one transaction per cycle while ready is high. A set closes on a
// transaction with last_in set or when the 64th value is taken; ready then drops until the
// whole sorted set has been delivered. Slots past the loaded count sort as the largest
// signed value and are never emitted.
// Sorting runs 21 compare-exchange stages with one comparator that reads a pair from two
// element banks and writes both back each cycle, covering all 32 pairs in a stage, with one
// turnaround state after each stage. After the last stage, o_out delivers one value per cycle
// in ascending order while the receiver keeps ready high, last_out set on the final one.
// If the receiver holds ready low, the output register keeps its transaction and the emit
// sequence waits; nothing is lost or repeated. Input ready returns once the last result is
// taken. Synchronous active-low reset empties the store and clears any pending output.
module bitonic_sorter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bs_in_if.sink      i_in,
    bs_out_if.source   o_out
);

    bs_pkg::t_cmd    w_cmd;
    bs_pkg::t_status w_status;
    logic            w_in_ready;

    bs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_in),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    bs_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_in_value         (i_in.value),
        .i_out_ready        (o_out.ready),
        .o_status           (w_status),
        .o_out_valid        (o_out.valid),
        .o_out_sorted_value (o_out.sorted_value),
        .o_out_last         (o_out.last_out)
    );

endmodule

// ===== sv/bs_ctrl.sv =====
// Controller of the bitonic sorter: load, sort stage sequencing and emit.
// Depends on bs_pkg; drives the command struct into bs_datapath.
module bs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    input  bs_pkg::t_status i_status,
    output logic            o_in_ready,
    output bs_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_SORT  = 5'b00010,
        ST_GAP   = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_DRAIN = 5'b10000
    } t_state;

    t_state                        r_state, n_state;
    logic [bs_pkg::CNT_W-1:0]      r_count, n_count;
    logic [bs_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic [bs_pkg::BANK_AW-1:0]    r_pair, n_pair;
    logic [bs_pkg::LOG_W-1:0]      r_jlog, n_jlog;
    logic [bs_pkg::LOG_W-1:0]      r_klog, n_klog;
    logic                          emit_last;

    assign emit_last = (r_idx + 1'b1 == r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pair     = r_pair;
        n_jlog     = r_jlog;
        n_klog     = r_klog;
        o_in_ready = 1'b0;
        o_cmd        = '0;
        o_cmd.op     = bs_pkg::OP_NOP;
        o_cmd.index  = r_idx[bs_pkg::IDX_W-1:0];
        o_cmd.last   = emit_last;
        o_cmd.pair   = r_pair;
        o_cmd.jlog   = r_jlog;
        o_cmd.klog   = r_klog;
        o_cmd.pad_en = (r_klog == bs_pkg::LOG_W'(1));
        o_cmd.count  = r_count;
        case (r_state)
            ST_LOAD: begin
                o_in_ready  = 1'b1;
                o_cmd.index = r_count[bs_pkg::IDX_W-1:0];
                if (i_in_valid) begin
                    o_cmd.op = bs_pkg::OP_LOAD;
                    n_count  = r_count + 1'b1;
                    if (i_in_last || (r_count + 1'b1 == bs_pkg::CNT_W'(bs_pkg::CAPACITY))) begin
                        n_state = ST_SORT;
                        n_klog  = bs_pkg::LOG_W'(1);
                        n_jlog  = '0;
                        n_pair  = '0;
                    end
                end
            end
            ST_SORT: begin
                o_cmd.op = bs_pkg::OP_CE;
                n_pair   = r_pair + 1'b1;
                if (r_pair == '1) begin
                    n_state = ST_GAP;
                end
            end
            ST_GAP: begin
                if (r_jlog == '0 && r_klog == bs_pkg::LAST_KLOG) begin
                    n_state = ST_EMIT;
                    n_idx   = '0;
                end else begin
                    n_state = ST_SORT;
                    if (r_jlog == '0) begin
                        n_klog = r_klog + 1'b1;
                        n_jlog = r_klog;
                    end else begin
                        n_jlog = r_jlog - 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = bs_pkg::OP_EMIT;
                    n_idx    = r_idx + 1'b1;
                    if (emit_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_status.out_free) begin
                    n_state = ST_LOAD;
                    n_count = '0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_idx   <= '0;
            r_pair  <= '0;
            r_jlog  <= '0;
            r_klog  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pair  <= n_pair;
            r_jlog  <= n_jlog;
            r_klog  <= n_klog;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bs_pkg::CNT_W'(bs_pkg::CAPACITY))
        else $error("Loaded count exceeds capacity.");

    a_merge_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SORT) |-> (r_jlog < r_klog && r_klog <= bs_pkg::LAST_KLOG))
        else $error("Merge distance out of range for the current stage.");

endmodule

// ===== sv/bs_datapath.sv =====
// Datapath of the bitonic sorter: two element banks, compare-exchange unit, output register.
// Depends on bs_pkg; executes the command struct issued by bs_ctrl.
module bs_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bs_pkg::t_cmd                     i_cmd,
    input  logic signed [bs_pkg::DATA_W-1:0] i_in_value,
    input  logic                             i_out_ready,
    output bs_pkg::t_status                  o_status,
    output logic                             o_out_valid,
    output logic signed [bs_pkg::DATA_W-1:0] o_out_sorted_value,
    output logic                             o_out_last
);

    logic [bs_pkg::DATA_W-1:0]  r_mem0 [bs_pkg::BANK_DEPTH];
    logic [bs_pkg::DATA_W-1:0]  r_mem1 [bs_pkg::BANK_DEPTH];
    logic [bs_pkg::DATA_W-1:0]  r_rd0, r_rd1;

    logic [bs_pkg::IDX_W-1:0]   low_mask, pair_ext, lo_idx, hi_idx;
    logic [bs_pkg::CNT_W-1:0]   lo_ext, hi_ext;
    logic                       lo_bank, desc, pad_lo, pad_hi;
    logic                       rd_en;
    logic [bs_pkg::BANK_AW-1:0] rd_addr0, rd_addr1;

    logic                       r_ce_vld;
    logic                       r_lo_bank, r_desc, r_pad_lo, r_pad_hi;
    logic [bs_pkg::BANK_AW-1:0] r_lo_addr, r_hi_addr;

    logic signed [bs_pkg::DATA_W-1:0] lo_val, hi_val, new_lo, new_hi;
    logic                       swap;

    logic                       wr_en0, wr_en1;
    logic [bs_pkg::BANK_AW-1:0] wr_addr0, wr_addr1;
    logic [bs_pkg::DATA_W-1:0]  wr_data0, wr_data1;

    logic                       r_out_vld, r_out_bank, r_out_last;

    always_comb begin
        low_mask = (bs_pkg::IDX_W'(1) << i_cmd.jlog) - bs_pkg::IDX_W'(1);
        pair_ext = {1'b0, i_cmd.pair};
        lo_idx   = ((pair_ext & ~low_mask) << 1) | (pair_ext & low_mask);
        hi_idx   = lo_idx | (bs_pkg::IDX_W'(1) << i_cmd.jlog);
        lo_ext   = {1'b0, lo_idx};
        hi_ext   = {1'b0, hi_idx};
        lo_bank  = ^lo_idx;
        desc     = lo_ext[i_cmd.klog];
        pad_lo   = i_cmd.pad_en && (lo_ext >= i_cmd.count);
        pad_hi   = i_cmd.pad_en && (hi_ext >= i_cmd.count);
        rd_en    = (i_cmd.op == bs_pkg::OP_CE) || (i_cmd.op == bs_pkg::OP_EMIT);
        if (i_cmd.op == bs_pkg::OP_CE) begin
            rd_addr0 = lo_bank ? hi_idx[bs_pkg::IDX_W-1:1] : lo_idx[bs_pkg::IDX_W-1:1];
            rd_addr1 = lo_bank ? lo_idx[bs_pkg::IDX_W-1:1] : hi_idx[bs_pkg::IDX_W-1:1];
        end else begin
            rd_addr0 = i_cmd.index[bs_pkg::IDX_W-1:1];
            rd_addr1 = i_cmd.index[bs_pkg::IDX_W-1:1];
        end
    end

    always_comb begin
        lo_val = r_pad_lo ? bs_pkg::PAD_VALUE : (r_lo_bank ? r_rd1 : r_rd0);
        hi_val = r_pad_hi ? bs_pkg::PAD_VALUE : (r_lo_bank ? r_rd0 : r_rd1);
        swap   = r_desc ? (lo_val < hi_val) : (lo_val > hi_val);
        new_lo = swap ? hi_val : lo_val;
        new_hi = swap ? lo_val : hi_val;
        if (i_cmd.op == bs_pkg::OP_LOAD) begin
            wr_en0   = ~(^i_cmd.index);
            wr_en1   = ^i_cmd.index;
            wr_addr0 = i_cmd.index[bs_pkg::IDX_W-1:1];
            wr_addr1 = i_cmd.index[bs_pkg::IDX_W-1:1];
            wr_data0 = i_in_value;
            wr_data1 = i_in_value;
        end else begin
            wr_en0   = r_ce_vld;
            wr_en1   = r_ce_vld;
            wr_addr0 = r_lo_bank ? r_hi_addr : r_lo_addr;
            wr_addr1 = r_lo_bank ? r_lo_addr : r_hi_addr;
            wr_data0 = r_lo_bank ? new_hi : new_lo;
            wr_data1 = r_lo_bank ? new_lo : new_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en0) begin
            r_mem0[wr_addr0] <= wr_data0;
        end
        if (rd_en) begin
            r_rd0 <= r_mem0[rd_addr0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en1) begin
            r_mem1[wr_addr1] <= wr_data1;
        end
        if (rd_en) begin
            r_rd1 <= r_mem1[rd_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_bank  <= lo_bank;
        r_lo_addr  <= lo_idx[bs_pkg::IDX_W-1:1];
        r_hi_addr  <= hi_idx[bs_pkg::IDX_W-1:1];
        r_desc     <= desc;
        r_pad_lo   <= pad_lo;
        r_pad_hi   <= pad_hi;
        if (i_cmd.op == bs_pkg::OP_EMIT) begin
            r_out_bank <= ^i_cmd.index;
            r_out_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ce_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_ce_vld <= (i_cmd.op == bs_pkg::OP_CE);
            if (i_cmd.op == bs_pkg::OP_EMIT) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_status.out_free  = !r_out_vld || i_out_ready;
    assign o_out_valid        = r_out_vld;
    assign o_out_sorted_value = r_out_bank ? r_rd1 : r_rd0;
    assign o_out_last         = r_out_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == bs_pkg::OP_EMIT) |-> (!r_out_vld || i_out_ready))
        else $error("Emit read issued while the output register is stalled.");

    a_no_load_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ce_vld |-> (i_cmd.op != bs_pkg::OP_LOAD))
        else $error("Load write collides with a compare-exchange write.");

    a_pad_first_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ce_vld && (r_pad_lo || r_pad_hi)) |-> $past(i_cmd.pad_en))
        else $error("Padding applied outside the first sorting stage.");

endmodule
